/* hw/rtl/leb128_varint_decoder_core_assert.svh */
// Assertion macros used by the checker of the LEB128 decoder.
`ifndef LEB128_VARINT_DECODER_CORE_ASSERT_SVH
`define LEB128_VARINT_DECODER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LEB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define LEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/leb_pkg.sv */
package leb_pkg;

  localparam int MAX_BYTES  = 10;
  localparam int IDX_W      = 4;
  localparam int PAYLOAD_W  = 7;
  localparam int VALUE_W    = 64;
  localparam int COUNT_W    = 4;
  localparam int SHIFT_W    = 7;
  localparam int OVF_SHIFT  = 63;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic                 last;
    logic                 cont;
    logic [PAYLOAD_W-1:0] payload;
  } leb_item_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic      valid;
    leb_item_t item;
  } leb_qout_t;

endpackage

/* hw/rtl/leb_queue.sv */
module leb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  leb_pkg::leb_item_t push_item,
  output logic              full,
  input  logic              pop,
  output leb_pkg::leb_qout_t head
);

  leb_pkg::leb_item_t                 mem [leb_pkg::QDEPTH];
  logic [leb_pkg::QPTR_W-1:0]         wr_ptr;
  logic [leb_pkg::QPTR_W-1:0]         rd_ptr;
  logic [leb_pkg::QCNT_W-1:0]         count;
  logic                               do_push;
  logic                               do_pop;

  assign full    = (count == leb_pkg::QCNT_W'(leb_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == leb_pkg::QPTR_W'(leb_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == leb_pkg::QPTR_W'(leb_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/leb_front.sv */
module leb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               pop,
  output leb_pkg::leb_qout_t head
);

  leb_pkg::leb_item_t item;
  logic               full;

  // Bit 7 marks a continuing byte; the low seven bits carry payload.
  assign item.cont    = in_byte[7];
  assign item.payload = in_byte[leb_pkg::PAYLOAD_W-1:0];
  assign item.last    = in_last;
  assign in_ready     = !full;

  leb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (item),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

endmodule

/* hw/rtl/leb_back.sv */
module leb_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  leb_pkg::leb_qout_t                  head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [leb_pkg::VALUE_W-1:0]         out_value,
  output logic [leb_pkg::COUNT_W-1:0]         out_count,
  output logic                                out_err
);

  logic                         signed_mode;
  logic [leb_pkg::VALUE_W-1:0]  accumulator;
  logic [leb_pkg::IDX_W-1:0]    byte_index;

  logic [leb_pkg::SHIFT_W-1:0]  shift;
  logic [leb_pkg::SHIFT_W-1:0]  after;
  logic [leb_pkg::VALUE_W-1:0]  merged;
  logic [leb_pkg::VALUE_W-1:0]  sext_mask;
  logic                         stray;
  logic                         overflow;
  logic                         finish_ok;
  logic                         finish_err;
  logic [leb_pkg::IDX_W-1:0]    idx_inc;

  assign shift   = leb_pkg::SHIFT_W'({3'b000, byte_index} * leb_pkg::SHIFT_W'(7));
  assign after   = shift + leb_pkg::SHIFT_W'(7);
  assign idx_inc = byte_index + 1'b1;
  assign merged  = accumulator
                 | ({{(leb_pkg::VALUE_W - leb_pkg::PAYLOAD_W){1'b0}}, head.item.payload}
                    << shift);

  always_comb begin
    sext_mask = '0;
    if (signed_mode && head.item.payload[leb_pkg::PAYLOAD_W-1] &&
        (after < leb_pkg::SHIFT_W'(leb_pkg::VALUE_W))) begin
      sext_mask = {leb_pkg::VALUE_W{1'b1}} << after;
    end
  end

  assign stray      = (byte_index >= leb_pkg::IDX_W'(leb_pkg::MAX_BYTES));
  assign overflow   = (shift >= leb_pkg::SHIFT_W'(leb_pkg::OVF_SHIFT)) &&
                      (head.item.payload > leb_pkg::PAYLOAD_W'(1));
  assign finish_ok  = !stray && !overflow && !head.item.cont;
  assign finish_err = stray || overflow ||
                      (head.item.cont &&
                       ((idx_inc >= leb_pkg::IDX_W'(leb_pkg::MAX_BYTES)) || head.item.last));

  assign pop = head.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      byte_index  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && (finish_ok || finish_err)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (finish_ok || finish_err) begin
          accumulator <= '0;
          byte_index  <= '0;
        end else begin
          accumulator <= merged;
          byte_index  <= idx_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (finish_ok || finish_err)) begin
      out_value <= finish_ok ? (merged | sext_mask) : '0;
      out_count <= finish_ok ? idx_inc : '0;
      out_err   <= !finish_ok;
    end
  end

endmodule

/* hw/rtl/leb128_varint_decoder_core.sv */
// A terminating byte passes the queue; the back end registers the result with tvalid.
// One byte per cycle is taken unless m_axis_tready stalls the single accumulate step.
// A two-entry queue between front and back lets either side stall without losing a byte.
// Reset is synchronous and active high; it empties the queue, clears the accumulator,
// the byte count and the output valid, and returns the mode register to unsigned.
module leb128_varint_decoder_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,      // signed_mode
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // data_byte
  input  logic                           s_axis_tlast,   // buffer_end
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [leb_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // decoded_value, bytes_used, zeros
  output logic                           m_axis_tuser    // decode_error
);

  leb_pkg::leb_qout_t               head;
  logic                             pop;
  logic [leb_pkg::VALUE_W-1:0]      out_value;
  logic [leb_pkg::COUNT_W-1:0]      out_count;

  leb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .pop      (pop),
    .head     (head)
  );

  leb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_count (out_count),
    .out_err   (m_axis_tuser)
  );

  assign m_axis_tdata = {{(leb_pkg::OUT_DATA_W - leb_pkg::VALUE_W - leb_pkg::COUNT_W){1'b0}},
                         out_count, out_value};

endmodule

/* hw/rtl/leb_checker.sv */
`include "leb128_varint_decoder_core_assert.svh"

module leb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic                           cfg_wdata,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [7:0]                     s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [leb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  `LEB_ASSERT_ALWAYS(a_err_zero, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata == '0), "An error transaction must carry a zero value and count.")

  `LEB_ASSERT_ALWAYS(a_count_range, !(m_axis_tvalid && !m_axis_tuser) || ((m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'(leb_pkg::MAX_BYTES))), "A good result must report between one and the maximum number of bytes.")

  `LEB_ASSERT_ALWAYS(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[leb_pkg::OUT_DATA_W-1:68] == '0), "The padding bits of tdata must be zero.")

  `LEB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "A stalled result must hold.")

endmodule

bind leb128_varint_decoder_core leb_checker u_checker (.*);
